FILE: rtl/core/cdq_pkg.sv
// cdq_pkg: shared types and codes for the circular deque.
// Used by cdq_cell and circular_deque; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,   // keep contents
        CELL_SHR  = 3'd1,   // shift towards rear, new word enters cell 0
        CELL_FILL = 3'd2,   // first empty cell takes the new word
        CELL_SHL  = 3'd3,   // shift towards front, cell 0 drops out
        CELL_DROP = 3'd4,   // tail cell goes empty
        CELL_ROT  = 3'd5    // shift towards front, cell 0 wraps to tail
    } cell_op_t;

    // What one cell shows its neighbours
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
    } cell_link_t;

    // Top-level control states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } ctrl_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/circular_deque.sv
// circular_deque: double-ended queue of DEPTH 32-bit words in a chain of cells.
// Push and pop: one item per cycle while the output is free, result in the cycle after acceptance.
// Dump of n stored words: n results, one per free output cycle,
// input held off meanwhile; dump of an empty store gives one result.
// Synchronous active-low reset empties the chain; stored words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input items
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [MODE_W-1:0]          s_mode,
    input  wire logic signed [WORD_W-1:0]   s_push_value,
    // result items
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic signed [WORD_W-1:0]        m_data,
    output logic                            m_last
);

    // ------------------------------------------------------------------
    // The deque is kept front-aligned: cell 0 holds the front word and the
    // valid cells form an unbroken run from cell 0 to the tail cell.
    // Every operation is a single broadcast to all cells, each of which
    // only looks at its direct neighbours (plus cell 0 for rotation and the push word).
    // A dump rotates the chain once per result, so after n beats the
    // contents are back where they started.
    // ------------------------------------------------------------------

    cell_link_t        links     [DEPTH];
    cell_link_t        left_in   [DEPTH];
    cell_link_t        right_in  [DEPTH];
    logic [DEPTH-1:0]  tail_vec;
    logic [DEPTH-1:0]  valid_vec;
    cell_op_t          cell_op;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                // a push at the front shifts the new word into cell 0
                assign left_in[g] = '{valid: 1'b1, data: s_push_value};
            end else begin : g_body
                assign left_in[g] = links[g-1];
            end
            if (g == DEPTH-1) begin : g_end
                assign right_in[g] = '{valid: 1'b0, data: '0};
            end else begin : g_mid
                assign right_in[g] = links[g+1];
            end

            cdq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .op         (cell_op),
                .left_link  (left_in[g]),
                .right_link (right_in[g]),
                .head_data  (links[0].data),
                .push_data  (s_push_value),
                .self_link  (links[g]),
                .is_tail    (tail_vec[g])
            );

            assign valid_vec[g] = links[g].valid;
        end
    endgenerate

    logic store_empty;
    logic store_full;

    assign store_empty = !links[0].valid;
    assign store_full  = links[DEPTH-1].valid;

    // rear word: one-hot pick by the tail flags
    logic [WORD_W-1:0] rear_data;

    always_comb begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_data = rear_data | (links[i].data & {WORD_W{tail_vec[i]}});
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [DEPTH-1:0]  token_reg;     // one-hot position of the dump beat
    logic [DEPTH-1:0]  token_next;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATUS_W-1:0] m_status_next;
    logic [WORD_W-1:0]   m_data_reg;
    logic [WORD_W-1:0]   m_data_next;
    logic                m_last_reg;
    logic                m_last_next;

    logic out_free;
    logic accept;
    logic dump_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign dump_last = |(token_reg & tail_vec);

    always_comb begin
        state_next    = state_reg;
        token_next    = token_reg;
        cell_op       = CELL_HOLD;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // every result from idle is a single, final one
                    m_status_next = STAT_OK;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    case (s_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                            m_valid_next = 1'b1;
                            if (store_full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                cell_op = (s_mode == MODE_PUSH_FRONT) ? CELL_SHR
                                                                      : CELL_FILL;
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_REAR: begin
                            m_valid_next = 1'b1;
                            if (store_empty) begin
                                m_status_next = STAT_EMPTY;
                            end else if (s_mode == MODE_POP_FRONT) begin
                                m_data_next = links[0].data;
                                cell_op     = CELL_SHL;
                            end else begin
                                m_data_next = rear_data;
                                cell_op     = CELL_DROP;
                            end
                        end
                        MODE_DUMP: begin
                            if (store_empty) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_EMPTY;
                            end else begin
                                state_next = ST_DUMP;
                                token_next = {{(DEPTH-1){1'b0}}, 1'b1};
                            end
                        end
                        default: begin
                            // unused modes: taken, no result
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_data_next   = links[0].data;
                    m_last_next   = dump_last;
                    cell_op       = CELL_ROT;
                    token_next    = {token_reg[DEPTH-2:0], 1'b0};
                    if (dump_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            token_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            token_reg   <= token_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // valid cells form one run from cell 0
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("valid cells not contiguous from the front");

    // at most one tail cell
    a_one_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tail_vec))
        else $error("more than one tail cell");

    // dump beat position is always defined while dumping
    a_dump_token: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DUMP |-> $onehot(token_reg))
        else $error("dump token lost");

    // push and pop items always give a result in the next cycle
    a_push_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_mode == MODE_PUSH_FRONT || s_mode == MODE_PUSH_REAR ||
                   s_mode == MODE_POP_FRONT || s_mode == MODE_POP_REAR)
        |=> m_valid_reg)
        else $error("push or pop item without result");

endmodule

`default_nettype wire

FILE: rtl/core/cdq_cell.sv
// cdq_cell: one storage cell of the deque chain (a word plus its valid bit).
// Depends on cdq_pkg for the link struct and the cell operation codes.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_op_t          op,
    input  wire cell_link_t        left_link,   // towards front
    input  wire cell_link_t        right_link,  // towards rear
    input  wire logic [WORD_W-1:0] head_data,   // cell 0 word, for rotation
    input  wire logic [WORD_W-1:0] push_data,
    output cell_link_t             self_link,
    output logic                   is_tail
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    assign is_tail   = valid_reg && !right_link.valid;
    assign self_link = '{valid: valid_reg, data: data_reg};

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (op)
            CELL_HOLD: begin
            end
            CELL_SHR: begin
                valid_next = left_link.valid;
                data_next  = left_link.data;
            end
            CELL_FILL: begin
                if (!valid_reg && left_link.valid) begin
                    valid_next = 1'b1;
                    data_next  = push_data;
                end
            end
            CELL_SHL: begin
                valid_next = right_link.valid;
                data_next  = right_link.data;
            end
            CELL_DROP: begin
                if (is_tail) begin
                    valid_next = 1'b0;
                end
            end
            CELL_ROT: begin
                data_next = is_tail ? head_data : right_link.data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking testbench for circular_deque, a double-ended queue held in a ring.
// Depends on cdq_pkg (modes, status codes, widths) and the circular_deque RTL only.
`timescale 1ns / 1ps

module tb;
    import cdq_pkg::*;

    localparam int DEPTH         = 8;
    localparam int RAND_ITEMS    = 100;   // counted random items (unused modes excluded)
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4 * DEPTH;
    localparam int REPORT_MAX    = 10;

    // modes the block ignores: no result, no change of state
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } deque_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [MODE_W-1:0]          s_mode = '0;
    logic signed [WORD_W-1:0]   s_push_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [WORD_W-1:0]   m_data;
    logic                       m_last;

    // Predicted contents of the deque, kept as a ring with head and tail indices
    logic signed [WORD_W-1:0]   ring_words [DEPTH];
    int                         head_idx = 0;
    int                         tail_idx = 0;
    logic                       occupied = 1'b0;

    deque_result_t              pending_results [$];
    int                         fault_count = 0;
    logic                       idle_on = 1'b1;   // random gaps on both sides when set
    logic                       hold_req = 1'b0;  // asks the receiver for a long hold-off

    circular_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data       (m_data),
        .m_last       (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int next_idx(input int i);
        return (i + 1) % DEPTH;
    endfunction

    function automatic int prev_idx(input int i);
        return (i + DEPTH - 1) % DEPTH;
    endfunction

    task automatic add_result(input logic [STATUS_W-1:0] status,
                              input logic signed [WORD_W-1:0] data, input logic last);
        deque_result_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    // Applies one accepted item to the predicted ring and queues its results.
    task automatic apply_deque_op(input logic [MODE_W-1:0] mode,
                                  input logic signed [WORD_W-1:0] word);
        int   idx;
        logic at_tail;
        logic signed [WORD_W-1:0] taken;
        case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (occupied && next_idx(tail_idx) == head_idx) begin
                    add_result(STAT_FULL, '0, 1'b1);
                end else begin
                    if (!occupied) begin
                        // first entry always lands at slot 0
                        head_idx      = 0;
                        tail_idx      = 0;
                        occupied      = 1'b1;
                        ring_words[0] = word;
                    end else if (mode == MODE_PUSH_FRONT) begin
                        head_idx             = prev_idx(head_idx);
                        ring_words[head_idx] = word;
                    end else begin
                        tail_idx             = next_idx(tail_idx);
                        ring_words[tail_idx] = word;
                    end
                    add_result(STAT_OK, '0, 1'b1);
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (!occupied) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    taken = (mode == MODE_POP_FRONT) ? ring_words[head_idx]
                                                     : ring_words[tail_idx];
                    if (head_idx == tail_idx) begin
                        // last entry gone: back to the reset picture
                        occupied = 1'b0;
                        head_idx = 0;
                        tail_idx = 0;
                    end else if (mode == MODE_POP_FRONT) begin
                        head_idx = next_idx(head_idx);
                    end else begin
                        tail_idx = prev_idx(tail_idx);
                    end
                    add_result(STAT_OK, taken, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (!occupied) begin
                    add_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    idx     = head_idx;
                    at_tail = 1'b0;
                    while (!at_tail) begin
                        at_tail = (idx == tail_idx);
                        add_result(STAT_OK, ring_words[idx], at_tail);
                        idx = next_idx(idx);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item and holds it until accepted. With no gap, valid stays high
    // so the next call simply replaces the payload.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic signed [WORD_W-1:0] word);
        int gap;
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_push_value <= word;
        do @(posedge aclk); while (!s_ready);
        apply_deque_op(mode, word);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Pops and dump on an empty ring, and the ignored modes.
    task automatic test_empty_ring();
        logic [MODE_W-1:0] m;
        send_item(MODE_POP_FRONT, pick_word());
        send_item(MODE_POP_REAR, pick_word());
        send_item(MODE_DUMP, pick_word());
        for (m = MODE_SPARE_LO; m != MODE_DUMP; m = m + 1'b1) begin
            send_item(m, pick_word());
            if (m == MODE_SPARE_HI) break;
        end
        wait_results_done();
    endtask

    // Single entry: push into empty, pop of the only entry, one-word dump.
    task automatic test_single_entry();
        send_item(MODE_PUSH_REAR, 32'sh0000_00a5);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_item(MODE_DUMP, '0);
        send_item(MODE_POP_REAR, '1);
        wait_results_done();
    endtask

    // Fill from both ends (front wraps below slot 0), push into full, dump full ring.
    task automatic test_full_ring();
        send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_item(MODE_PUSH_REAR, 32'sh7fff_ffff);
        send_item(MODE_PUSH_FRONT, '0);
        send_item(MODE_PUSH_REAR, '1);
        send_item(MODE_PUSH_FRONT, 32'sh0000_0001);
        send_item(MODE_PUSH_REAR, 32'shaaaa_aaaa);
        send_item(MODE_PUSH_FRONT, 32'sh5555_5555);
        send_item(MODE_PUSH_REAR, 32'sh1234_5678);
        send_item(MODE_PUSH_FRONT, pick_word());
        send_item(MODE_PUSH_REAR, pick_word());
        send_item(MODE_DUMP, '0);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_POP_REAR, '0);
        wait_results_done();
    endtask

    // Receiver holds off for a long stretch while the sender keeps going, so
    // results back up and the input stalls; then the sender waits for all of them.
    task automatic test_back_pressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        wait (!hold_req);
        send_item(MODE_DUMP, '0);
        send_item(MODE_PUSH_REAR, pick_word());
        send_item(MODE_PUSH_FRONT, pick_word());
        send_item(MODE_DUMP, '0);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_POP_REAR, '0);
        send_item(MODE_DUMP, '0);
        send_item(MODE_PUSH_FRONT, pick_word());
        wait_results_done();
        idle_on = 1'b1;
    endtask

    // Random items in segments that lean towards filling or emptying, so that
    // full and empty are both reached often; every fourth segment runs without gaps.
    task automatic test_random_ops();
        int counted;
        int segment;
        int r;
        logic filling;
        logic [MODE_W-1:0] mode;
        counted = 0;
        while (counted < RAND_ITEMS) begin
            segment = counted / 20;
            filling = (segment % 2) == 0;
            idle_on = (segment % 4) != 3;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            end else if (r < 12) begin
                mode = MODE_DUMP;
            end else if ((r < 72) == filling) begin
                mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            end else begin
                mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
            end
            send_item(mode, pick_word());
            if (mode < MODE_SPARE_LO) counted++;
        end
        idle_on = 1'b1;
        wait_results_done();
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, or one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------
    // Result checker: each accepted result against the oldest prediction
    // ---------------------------------------------------------------
    task automatic note_fault(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin : check_result
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: unexpected result: status %0d data %h last %b",
                             $realtime, m_status, m_data, m_last);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    note_fault("status", WORD_W'(want.status), WORD_W'(m_status));
                if (m_data !== want.data)
                    note_fault("data", want.data, m_data);
                if (m_last !== want.last)
                    note_fault("last", WORD_W'(want.last), WORD_W'(m_last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ---------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence of tests
    // ---------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ring();
        test_single_entry();
        test_full_ring();
        test_back_pressure();
        test_random_ops();

        // let any stray result show itself before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("%0d results never arrived", pending_results.size());
        end
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
